@@ hdl/lens_distortion_remap_defines.svh @@
// ----------------------------------------------------------------------------
// lens_distortion_remap assertion macros
// Short forms for the concurrent checks of the remap block; they expect a
// clk and an active-high rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_REMAP_DEFINES_SVH
`define LENS_DISTORTION_REMAP_DEFINES_SVH

// same-cycle implication
`define LDR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lens_distortion_remap: same-cycle check failed");

// next-cycle implication
`define LDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lens_distortion_remap: next-cycle check failed");

`endif

@@ hdl/ldr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types, register codes and helper functions (one a saturating add).
// ----------------------------------------------------------------------------
`default_nettype none

package ldr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 28;

  // working values are clamped to +-2^61, so 63 signed bits hold them
  localparam int VAL_W = 63;
  typedef logic signed [VAL_W-1:0] val_t;
  localparam val_t VMAX = {2'b01, {(VAL_W-2){1'b0}}};

  localparam int DIV_STEP = 2;  // quotient bits per divider stage

  localparam int CFG_IDX_W = 8;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIAL_K1       = 8'd0,
    REG_RADIAL_K2       = 8'd1,
    REG_RADIAL_K3       = 8'd2,
    REG_TANGENTIAL_P1   = 8'd3,
    REG_TANGENTIAL_P2   = 8'd4,
    REG_FOCAL_LENGTHS   = 8'd5,
    REG_PRINCIPAL_POINT = 8'd6,
    REG_IMAGE_SIZE      = 8'd7
  } reg_idx_t;

  localparam logic [63:0] FOCAL_RESET = 64'h0001_0000_0001_0000;

  function automatic int div_stages(int frac);
    return (32 + frac + 1 + DIV_STEP - 1) / DIV_STEP;
  endfunction

  function automatic val_t sx32(logic [31:0] v);
    return {{(VAL_W-32){v[31]}}, v};
  endfunction

  // saturating add
  function automatic val_t addv(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] lim;
    s   = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    lim = {1'b0, VMAX};
    if (s > lim) begin
      return VMAX;
    end else if (s < -lim) begin
      return -VMAX;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/ldr_delay.sv @@
// ----------------------------------------------------------------------------
// ldr_delay
// Stallable delay line that keeps side operands aligned with the multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

`default_nettype wire

@@ hdl/ldr_mulq.sv @@
// ----------------------------------------------------------------------------
// ldr_mulq
// Pipelined fixed-point multiply: |a|*|b| from four 31x31 partial products,
// rounded half away from zero by FRAC bits, saturated to 2^61.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_mulq #(
  parameter int FRAC = ldr_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire ldr_pkg::val_t a,
  input  wire ldr_pkg::val_t b,
  output ldr_pkg::val_t    p
);

  localparam int MAG_W  = ldr_pkg::VAL_W - 1;
  localparam int LIMB   = MAG_W / 2;
  localparam int PP_W   = 2 * LIMB;
  localparam int PROD_W = 2 * MAG_W;

  ldr_pkg::val_t     a0, b0;
  logic              neg1, neg2, neg3;
  logic [PP_W-1:0]   pp00, pp01, pp10, pp11;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mag;

  ldr_pkg::val_t     ta, tb;
  logic [MAG_W-1:0]  ma, mb;
  logic [PROD_W-1:0] rsum, rsh;
  ldr_pkg::val_t     pm;

  always_comb begin
    ta   = a0[ldr_pkg::VAL_W-1] ? -a0 : a0;
    tb   = b0[ldr_pkg::VAL_W-1] ? -b0 : b0;
    ma   = ta[MAG_W-1:0];
    mb   = tb[MAG_W-1:0];
    rsum = prod + (PROD_W'(1) << (FRAC - 1));
    rsh  = rsum >> FRAC;
    pm   = {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0   <= a;
      b0   <= b;
      neg1 <= a0[ldr_pkg::VAL_W-1] ^ b0[ldr_pkg::VAL_W-1];
      pp00 <= ma[LIMB-1:0] * mb[LIMB-1:0];
      pp01 <= ma[LIMB-1:0] * mb[MAG_W-1:LIMB];
      pp10 <= ma[MAG_W-1:LIMB] * mb[LIMB-1:0];
      pp11 <= ma[MAG_W-1:LIMB] * mb[MAG_W-1:LIMB];
      neg2 <= neg1;
      prod <= PROD_W'(pp00) + ((PROD_W'(pp01) + PROD_W'(pp10)) << LIMB)
              + (PROD_W'(pp11) << (2 * LIMB));
      neg3 <= neg2;
      if (rsh > PROD_W'(ldr_pkg::VMAX)) begin
        mag <= ldr_pkg::VMAX[MAG_W-1:0];
      end else begin
        mag <= rsh[MAG_W-1:0];
      end
      p <= neg3 ? -pm : pm;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ldr_norm.sv @@
// ----------------------------------------------------------------------------
// ldr_norm
// Pipelined normalizer: ((p << 16) - c) / f with FRAC fraction bits, rounded
// half away from zero. Restoring division, DIV_STEP quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_norm #(
  parameter int FRAC = ldr_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [15:0] p,
  input  wire logic [31:0] c,
  input  wire logic [31:0] f,
  output ldr_pkg::val_t    q
);

  localparam int NW   = 32 + FRAC + 1;
  localparam int STEP = ldr_pkg::DIV_STEP;
  localparam int NS   = ldr_pkg::div_stages(FRAC);

  logic [31:0]   rem [NS+1];
  logic [NW-1:0] wrk [NS+1];
  logic          ngs [NS+1];

  logic signed [33:0] d;
  logic [31:0]        m;
  logic [63:0]        qw;
  ldr_pkg::val_t      clip;

  always_comb begin
    d    = $signed({2'b00, p, 16'h0000}) - $signed({2'b00, c});
    m    = d[33] ? 32'(-d) : d[31:0];
    qw   = 64'(wrk[NS]);
    clip = (qw > 64'(ldr_pkg::VMAX)) ? ldr_pkg::VMAX : qw[ldr_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      ngs[0] <= d[33];
      wrk[0] <= NW'({m, {FRAC{1'b0}}}) + NW'(f >> 1);
      q      <= ngs[NS] ? -clip : clip;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [31:0]   rr;
    logic [NW-1:0] ww;

    always_comb begin : step_c
      logic [32:0] t;
      t  = '0;
      rr = rem[s];
      ww = wrk[s];
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < NW) begin
          t  = {rr, ww[NW-1]};
          ww = {ww[NW-2:0], 1'b0};
          if (t >= {1'b0, f}) begin
            t     = t - {1'b0, f};
            ww[0] = 1'b1;
          end
          rr = t[31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rr;
        wrk[s+1] <= ww;
        ngs[s+1] <= ngs[s];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/lens_distortion_remap.sv @@
// ----------------------------------------------------------------------------
// lens_distortion_remap
// Brown-Conrady remap address generator: output pixel in, source pixel out.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one request per output pixel (out_x, out_y); m_axis returns
//    the source pixel (src_x, src_y) with in_bounds on tuser, in request order.
//  - cfg writes one register (index, data); always ready. Write only while the
//    pipe is empty.
//  - Throughput: one request per clock, sustained while m_axis does not stall.
//  - From accept to m_axis_tvalid a request passes the divider stages of the
//    normalizer and six chained multipliers.
//  - Reset clears the registers to their defaults (unit focal lengths) and
//    drops all requests in flight; tready stays low during reset.
//  - A stalled m_axis fills a one-entry skid stage, then s_axis_tready drops
//    and the whole pipe holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lens_distortion_remap_defines.svh"

module lens_distortion_remap #(
  parameter int COORD_BITS      = ldr_pkg::COORD_BITS_DEF,
  parameter int COEFF_FRAC_BITS = ldr_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // out_x [15:0], out_y [31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // src_x [15:0], src_y [31:16]
  output logic             m_axis_tuser,   // in_bounds [0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ldr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int NS    = ldr_pkg::div_stages(COEFF_FRAC_BITS);
  localparam int LAT   = NS + 39;
  localparam int PIX_W = 46;
  localparam logic [15:0] CMASK = 16'((17'd1 << COORD_BITS) - 17'd1);
  localparam ldr_pkg::val_t ONE = ldr_pkg::val_t'(64'd1 << COEFF_FRAC_BITS);

  // configuration registers
  logic [31:0] radial_k1, radial_k2, radial_k3, tangential_p1, tangential_p2;
  logic [63:0] focal_lengths, principal_point;
  logic [31:0] image_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radial_k1       <= '0;
      radial_k2       <= '0;
      radial_k3       <= '0;
      tangential_p1   <= '0;
      tangential_p2   <= '0;
      focal_lengths   <= ldr_pkg::FOCAL_RESET;
      principal_point <= '0;
      image_size      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ldr_pkg::REG_RADIAL_K1:       radial_k1       <= cfg_data[31:0];
        ldr_pkg::REG_RADIAL_K2:       radial_k2       <= cfg_data[31:0];
        ldr_pkg::REG_RADIAL_K3:       radial_k3       <= cfg_data[31:0];
        ldr_pkg::REG_TANGENTIAL_P1:   tangential_p1   <= cfg_data[31:0];
        ldr_pkg::REG_TANGENTIAL_P2:   tangential_p2   <= cfg_data[31:0];
        ldr_pkg::REG_FOCAL_LENGTHS:   focal_lengths   <= cfg_data;
        ldr_pkg::REG_PRINCIPAL_POINT: principal_point <= cfg_data;
        ldr_pkg::REG_IMAGE_SIZE:      image_size      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] fx, fy, cx, cy;
  logic [15:0] img_w, img_h;
  ldr_pkg::val_t k1, k2, k3, p1, p2;

  assign fx    = focal_lengths[63:32];
  assign fy    = focal_lengths[31:0];
  assign cx    = principal_point[63:32];
  assign cy    = principal_point[31:0];
  assign img_w = image_size[31:16];
  assign img_h = image_size[15:0];
  assign k1    = ldr_pkg::sx32(radial_k1);
  assign k2    = ldr_pkg::sx32(radial_k2);
  assign k3    = ldr_pkg::sx32(radial_k3);
  assign p1    = ldr_pkg::sx32(tangential_p1);
  assign p2    = ldr_pkg::sx32(tangential_p2);

  // pipe control
  logic en;
  logic [LAT:0] vld;
  logic out_valid, skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:0], s_axis_tvalid};
    end
  end

  // input stage
  logic [15:0] px, py;

  always_ff @(posedge clk) begin
    if (en) begin
      px <= s_axis_tdata[15:0] & CMASK;
      py <= s_axis_tdata[31:16] & CMASK;
    end
  end

  // normalize
  ldr_pkg::val_t xi, yi;

  ldr_norm #(.FRAC(COEFF_FRAC_BITS)) u_norm_x (
    .clk(clk), .en(en), .p(px), .c(cx), .f(fx), .q(xi));
  ldr_norm #(.FRAC(COEFF_FRAC_BITS)) u_norm_y (
    .clk(clk), .en(en), .p(py), .c(cy), .f(fy), .q(yi));

  // squares and cross term
  ldr_pkg::val_t x2, y2, txy;

  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_x2 (
    .clk(clk), .en(en), .a(xi), .b(xi), .p(x2));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_y2 (
    .clk(clk), .en(en), .a(yi), .b(yi), .p(y2));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_xy (
    .clk(clk), .en(en), .a(xi), .b(yi), .p(txy));

  ldr_pkg::val_t r2, t2, x2d, y2d, qx, qy;

  always_ff @(posedge clk) begin
    if (en) begin
      r2  <= ldr_pkg::addv(x2, y2);
      t2  <= ldr_pkg::addv(txy, txy);
      x2d <= ldr_pkg::addv(x2, x2);
      y2d <= ldr_pkg::addv(y2, y2);
      qx  <= ldr_pkg::addv(r2, x2d);
      qy  <= ldr_pkg::addv(r2, y2d);
    end
  end

  // radial polynomial, Horner form
  ldr_pkg::val_t u, v, w, r2_c, r2_d, kr;

  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(5)) u_dly_r2c (
    .clk(clk), .en(en), .d(r2), .q(r2_c));
  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(10)) u_dly_r2d (
    .clk(clk), .en(en), .d(r2), .q(r2_d));

  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_k3 (
    .clk(clk), .en(en), .a(k3), .b(r2), .p(u));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_k2 (
    .clk(clk), .en(en), .a(ldr_pkg::addv(u, k2)), .b(r2_c), .p(v));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_k1 (
    .clk(clk), .en(en), .a(ldr_pkg::addv(v, k1)), .b(r2_d), .p(w));

  always_ff @(posedge clk) begin
    if (en) begin
      kr <= ldr_pkg::addv(w, ONE);
    end
  end

  // distortion terms
  ldr_pkg::val_t xi_e, yi_e, t2_e, qx_e, qy_e;

  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(22)) u_dly_xi (
    .clk(clk), .en(en), .d(xi), .q(xi_e));
  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(22)) u_dly_yi (
    .clk(clk), .en(en), .d(yi), .q(yi_e));
  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(16)) u_dly_t2 (
    .clk(clk), .en(en), .d(t2), .q(t2_e));
  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(15)) u_dly_qx (
    .clk(clk), .en(en), .d(qx), .q(qx_e));
  ldr_delay #(.WIDTH(ldr_pkg::VAL_W), .DEPTH(15)) u_dly_qy (
    .clk(clk), .en(en), .d(qy), .q(qy_e));

  ldr_pkg::val_t xk, yk, p1t, p2q, p1q, p2t;

  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_xk (
    .clk(clk), .en(en), .a(xi_e), .b(kr), .p(xk));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_yk (
    .clk(clk), .en(en), .a(yi_e), .b(kr), .p(yk));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_p1t (
    .clk(clk), .en(en), .a(p1), .b(t2_e), .p(p1t));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_p2q (
    .clk(clk), .en(en), .a(p2), .b(qx_e), .p(p2q));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_p1q (
    .clk(clk), .en(en), .a(p1), .b(qy_e), .p(p1q));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_p2t (
    .clk(clk), .en(en), .a(p2), .b(t2_e), .p(p2t));

  ldr_pkg::val_t sxa, sya, p2q_d, p2t_d, xc, yc;

  always_ff @(posedge clk) begin
    if (en) begin
      sxa   <= ldr_pkg::addv(xk, p1t);
      sya   <= ldr_pkg::addv(yk, p1q);
      p2q_d <= p2q;
      p2t_d <= p2t;
      xc    <= ldr_pkg::addv(sxa, p2q_d);
      yc    <= ldr_pkg::addv(sya, p2t_d);
    end
  end

  // back to pixel units
  ldr_pkg::val_t mxf, myf, vx, vy;

  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_fx (
    .clk(clk), .en(en), .a(xc), .b(ldr_pkg::val_t'({31'd0, fx})), .p(mxf));
  ldr_mulq #(.FRAC(COEFF_FRAC_BITS)) u_mul_fy (
    .clk(clk), .en(en), .a(yc), .b(ldr_pkg::val_t'({31'd0, fy})), .p(myf));

  ldr_pkg::val_t ax, ay;
  logic              negx, negy;
  logic [PIX_W-1:0]  nx, ny;

  assign ax = vx[ldr_pkg::VAL_W-1] ? -vx : vx;
  assign ay = vy[ldr_pkg::VAL_W-1] ? -vy : vy;

  always_ff @(posedge clk) begin
    if (en) begin
      vx   <= ldr_pkg::addv(mxf, ldr_pkg::val_t'({31'd0, cx}));
      vy   <= ldr_pkg::addv(myf, ldr_pkg::val_t'({31'd0, cy}));
      negx <= vx[ldr_pkg::VAL_W-1];
      negy <= vy[ldr_pkg::VAL_W-1];
      nx   <= PIX_W'((ax + ldr_pkg::val_t'(32768)) >>> 16);
      ny   <= PIX_W'((ay + ldr_pkg::val_t'(32768)) >>> 16);
    end
  end

  // {ok, coordinate}, saturated to the image edge
  function automatic logic [16:0] to_pix(logic neg, logic [PIX_W-1:0] n,
                                         logic [15:0] size);
    if (neg && n != '0) begin
      return 17'd0;
    end
    if (size == 16'd0) begin
      return 17'd0;
    end
    if (n >= PIX_W'(size)) begin
      return {1'b0, size - 16'd1};
    end
    return {1'b1, n[15:0]};
  endfunction

  logic [16:0] pix_x, pix_y;
  logic [15:0] fin_x, fin_y;
  logic        fin_b;

  assign pix_x = to_pix(negx, nx, img_w);
  assign pix_y = to_pix(negy, ny, img_h);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fx == 32'd0 || fy == 32'd0) begin
        fin_x <= '0;
        fin_y <= '0;
        fin_b <= 1'b0;
      end else begin
        fin_x <= pix_x[15:0] & CMASK;
        fin_y <= pix_y[15:0] & CMASK;
        fin_b <= pix_x[16] & pix_y[16];
      end
    end
  end

  // output register and skid stage
  logic [15:0] out_x, out_y, skid_x, skid_y;
  logic        out_b, skid_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vld[LAT];
      end
    end else if (vld[LAT] && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_x <= skid_x;
        out_y <= skid_y;
        out_b <= skid_b;
      end else begin
        out_x <= fin_x;
        out_y <= fin_y;
        out_b <= fin_b;
      end
    end else if (en) begin
      skid_x <= fin_x;
      skid_y <= fin_y;
      skid_b <= fin_b;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_b;

  `LDR_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid)
  `LDR_ASSERT_NEXT(a_skid_fill, out_valid && !m_axis_tready && !skid_valid && vld[LAT], skid_valid)
  `LDR_ASSERT_NEXT(a_skid_drain, skid_valid && m_axis_tready, !skid_valid && out_valid)

endmodule

`default_nettype wire

@@ tb/tb_lens_distortion_remap.sv @@
// ----------------------------------------------------------------------------
// tb_lens_distortion_remap
// Self-checking bench for the lens distortion remap block. A stimulus table
// covers reset defaults, zero focal length and extreme settings. Random
// phases follow, each with its own camera setup. Every source pixel is
// compared with a fixed-point Brown-Conrady predictor or a typed table value.
// Both stream sides idle at random; output holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lens_distortion_remap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC        = ldr_pkg::FRAC_BITS_DEF;
  localparam longint      SAT         = longint'(1) << 61;
  localparam logic [7:0]  IDX_SPARE   = 8'hC3;  // not a register
  localparam int          RAND_ITEMS  = 1950;
  localparam int          DRAIN_WAIT  = 80;
  localparam int          HOLD_CYC    = 1000;
  localparam longint      CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic        ib;
  } pix_t;

  typedef struct {
    logic [31:0] k1, k2, k3, p1, p2;
    logic [63:0] focal, pp;
    logic [31:0] size;
  } cam_t;

  typedef struct {
    int          ph;
    logic [15:0] x, y;
    bit          typed;
    pix_t        want;
  } row_t;

  typedef struct {
    bit   typed;
    pix_t want;
  } hint_t;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  lens_distortion_remap u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cam_t   cam;          // settings the block currently holds
  pix_t   pending_pix[$];
  hint_t  hint_q[$];
  int     errors, n_sent, n_got, n_inside, n_phases;
  longint cycles;
  bit     steady;       // no idling on either side this phase
  bit     hold_arm;     // the random bursts have begun
  bit     hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint sat61(longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint sadd(longint a, longint b);
    return sat61(sat61(a) + sat61(b));
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // product rescaled by FRAC bits, rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  ma, mb;
    bit           neg;
    a   = sat61(a);
    b   = sat61(b);
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = {64'd0, ma} * {64'd0, mb};
    p   = (p + (128'd1 << (FRAC - 1))) >> FRAC;
    if (p > 128'(SAT)) p = 128'(SAT);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint norm(logic [15:0] p, logic [31:0] c, logic [31:0] f);
    longint      d;
    logic [63:0] m, q;
    d = (longint'(p) << 16) - longint'(c);
    m = (d < 0) ? -d : d;
    q = ((m << FRAC) + {33'd0, f[31:1]}) / {32'd0, f};
    if (q > 64'(SAT)) q = 64'(SAT);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] pixel_of(longint v, logic [15:0] size, ref bit ok);
    logic [63:0] m, n;
    m = (v < 0) ? -v : v;
    n = (m + 64'd32768) >> 16;
    if (v < 0 && n != 0) begin
      ok = 1'b0;
      return 16'd0;
    end
    if (size == 0) begin
      ok = 1'b0;
      return 16'd0;
    end
    if (n >= size) begin
      ok = 1'b0;
      return size - 16'd1;
    end
    return n[15:0];
  endfunction

  function automatic pix_t source_pixel(logic [15:0] px, logic [15:0] py);
    logic [31:0] fx, fy, cx, cy;
    longint      xi, yi, x2, y2, r2, txy, kr, xc, yc;
    bit          ok;
    pix_t        r;
    fx = cam.focal[63:32];
    fy = cam.focal[31:0];
    cx = cam.pp[63:32];
    cy = cam.pp[31:0];
    ok = 1'b1;
    if (fx == 0 || fy == 0) return '0;
    xi  = norm(px, cx, fx);
    yi  = norm(py, cy, fy);
    x2  = qmul(xi, xi);
    y2  = qmul(yi, yi);
    r2  = sadd(x2, y2);
    txy = qmul(xi, yi);
    txy = sadd(txy, txy);
    kr  = qmul(sadd(qmul(s32(cam.k3), r2), s32(cam.k2)), r2);
    kr  = qmul(sadd(kr, s32(cam.k1)), r2);
    kr  = sadd(kr, longint'(1) << FRAC);
    xc  = sadd(sadd(qmul(xi, kr), qmul(s32(cam.p1), txy)),
               qmul(s32(cam.p2), sadd(r2, sadd(x2, x2))));
    yc  = sadd(sadd(qmul(yi, kr), qmul(s32(cam.p1), sadd(r2, sadd(y2, y2)))),
               qmul(s32(cam.p2), txy));
    r.sx = pixel_of(sadd(qmul(xc, longint'(fx)), longint'(cx)), cam.size[31:16], ok);
    r.sy = pixel_of(sadd(qmul(yc, longint'(fy)), longint'(cy)), cam.size[15:0], ok);
    r.ib = ok;
    return r;
  endfunction

  // ---------------- monitor / scoreboard ----------------
  always @(posedge clk) begin
    hint_t h;
    pix_t  got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      h = hint_q.pop_front();
      pending_pix.push_back(h.typed ? h.want
                                    : source_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16]));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser};
      n_got++;
      if (got.ib) n_inside++;
      if (pending_pix.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = pending_pix.pop_front();
        if (got.sx !== want.sx) begin
          errors++;
          $display("%0t src_x: expected %0d, actual %0d", $time, want.sx, got.sx);
        end
        if (got.sy !== want.sy) begin
          errors++;
          $display("%0t src_y: expected %0d, actual %0d", $time, want.sy, got.sy);
        end
        if (got.ib !== want.ib) begin
          errors++;
          $display("%0t in_bounds: expected %0b, actual %0b", $time, want.ib, got.ib);
        end
      end
    end
  end

  // ---------------- result side ----------------
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (!hold_done && hold_arm) begin
        gap       = HOLD_CYC;   // long back-pressure: pipe fills, input stalls
        hold_done = 1'b1;
      end
      repeat (gap) @(negedge clk) m_axis_tready <= 1'b0;
      @(negedge clk) m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // ---------------- request side ----------------
  task automatic send(logic [15:0] x, logic [15:0] y, bit typed, pix_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
    @(negedge clk);
    hint_q.push_back('{typed, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic reg_write(logic [7:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ldr_pkg::REG_RADIAL_K1:       cam.k1    = val[31:0];
      ldr_pkg::REG_RADIAL_K2:       cam.k2    = val[31:0];
      ldr_pkg::REG_RADIAL_K3:       cam.k3    = val[31:0];
      ldr_pkg::REG_TANGENTIAL_P1:   cam.p1    = val[31:0];
      ldr_pkg::REG_TANGENTIAL_P2:   cam.p2    = val[31:0];
      ldr_pkg::REG_FOCAL_LENGTHS:   cam.focal = val;
      ldr_pkg::REG_PRINCIPAL_POINT: cam.pp    = val;
      ldr_pkg::REG_IMAGE_SIZE:      cam.size  = val[31:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_camera(cam_t c);
    reg_write(IDX_SPARE, {$urandom, $urandom});
    reg_write(ldr_pkg::REG_RADIAL_K1, {32'd0, c.k1});
    reg_write(ldr_pkg::REG_RADIAL_K2, {32'd0, c.k2});
    reg_write(ldr_pkg::REG_RADIAL_K3, {32'd0, c.k3});
    reg_write(ldr_pkg::REG_TANGENTIAL_P1, {32'd0, c.p1});
    reg_write(ldr_pkg::REG_TANGENTIAL_P2, {32'd0, c.p2});
    reg_write(ldr_pkg::REG_FOCAL_LENGTHS, c.focal);
    reg_write(ldr_pkg::REG_PRINCIPAL_POINT, c.pp);
    reg_write(ldr_pkg::REG_IMAGE_SIZE, {32'd0, c.size});
    n_phases++;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [31:0] small_coeff(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic cam_t random_camera();
    cam_t        c;
    logic [15:0] w, h;
    if ($urandom_range(0, 4) == 0) begin
      c = '{$urandom, $urandom, $urandom, $urandom, $urandom,
            {$urandom, $urandom}, {$urandom, $urandom}, $urandom};
    end else begin
      w = 16'($urandom_range(16, 2048));
      h = 16'($urandom_range(16, 2048));
      c.k1    = small_coeff(1 << 27);
      c.k2    = small_coeff(1 << 25);
      c.k3    = small_coeff(1 << 23);
      c.p1    = small_coeff(1 << 21);
      c.p2    = small_coeff(1 << 21);
      c.focal = {16'($urandom_range(100, 3000)), 16'($urandom),
                 16'($urandom_range(100, 3000)), 16'($urandom)};
      c.pp    = {(32'(w) << 15) + 32'($urandom_range(0, 1 << 20)),
                 (32'(h) << 15) + 32'($urandom_range(0, 1 << 20))};
      c.size  = {w, h};
    end
    return c;
  endfunction

  cam_t dir_cam[5];
  row_t plan[$];

  initial begin
    cam_t        c;
    int          n_rand, burst;
    logic [15:0] x, y, w, h;
    int          ph;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cycles = 0;
    errors = 0;
    steady = 1'b0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    cam = '{0, 0, 0, 0, 0, ldr_pkg::FOCAL_RESET, 64'd0, 32'd0};

    dir_cam[0] = cam;
    // realistic 640x480 camera, barrel distortion
    dir_cam[2] = '{-32'sd80530637, 32'sd26843546, 32'd0, 32'sd268435, -32'sd268435,
                   {32'd800 << 16, 32'd800 << 16}, {32'd320 << 16, 32'd240 << 16},
                   {16'd640, 16'd480}};
    dir_cam[1] = dir_cam[2];
    dir_cam[1].focal = {32'd0, 32'd800 << 16};   // zero fx
    dir_cam[3] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 32'hFFFFFFFF};
    dir_cam[4] = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   64'h00000001_00000001, 64'd0, 32'h0010_0010};

    plan = '{
      '{0, 16'd0,      16'd0,      1, '0},   // reset: zero image size
      '{0, 16'hFFFF,   16'hFFFF,   1, '0},
      '{0, 16'h1234,   16'hABCD,   1, '0},
      '{1, 16'd320,    16'd240,    1, '0},   // zero focal length
      '{1, 16'hFFFF,   16'd0,      1, '0},
      '{2, 16'd0,      16'd0,      0, '0},
      '{2, 16'd639,    16'd479,    0, '0},
      '{2, 16'd320,    16'd240,    0, '0},
      '{2, 16'd640,    16'd480,    0, '0},
      '{2, 16'hFFFF,   16'hFFFF,   0, '0},
      '{2, 16'd0,      16'd479,    0, '0},
      '{2, 16'd639,    16'd0,      0, '0},
      '{2, 16'd100,    16'd400,    0, '0},
      '{3, 16'd0,      16'd0,      0, '0},
      '{3, 16'hFFFF,   16'hFFFF,   0, '0},
      '{3, 16'h8000,   16'h8000,   0, '0},
      '{4, 16'd0,      16'd0,      0, '0},
      '{4, 16'hFFFF,   16'hFFFF,   0, '0},
      '{4, 16'd1,      16'd1,      0, '0},
      '{4, 16'd15,     16'd16,     0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    ph = 0;
    foreach (plan[i]) begin
      if (plan[i].ph != ph) begin
        wait_idle();
        ph = plan[i].ph;
        load_camera(dir_cam[ph]);
      end
      send(plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      wait_idle();
      c = random_camera();
      load_camera(c);
      hold_arm = 1'b1;   // first random burst is long enough to fill the pipe
      w = c.size[31:16];
      h = c.size[15:0];
      burst = $urandom_range(150, 320);
      if (burst > RAND_ITEMS - n_rand) burst = RAND_ITEMS - n_rand;
      repeat (burst) begin
        if ($urandom_range(0, 4) == 0) begin
          x = 16'($urandom);
          y = 16'($urandom);
        end else begin
          x = 16'($urandom_range(0, (w > 16'd57000) ? 16'hFFFF : w + w / 8));
          y = 16'($urandom_range(0, (h > 16'd57000) ? 16'hFFFF : h + h / 8));
        end
        send(x, y, 0, '0);
        n_rand++;
      end
    end
    wait_idle();

    $display("covered %0d requests over %0d camera setups, %0d results, %0d in bounds",
             n_sent, n_phases, n_got, n_inside);
    $display("one long output stall taken: %0b, mismatches: %0d", hold_done, errors);
    if (errors == 0 && pending_pix.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
